// File: src/bre_pkg.sv
// ----------------------------------------------------------------------------
// bre_pkg
// Shared types and constants for the BER REAL binary encoder.
// ----------------------------------------------------------------------------
package bre_pkg;

    localparam int MAX_OCTETS  = 10;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [10:0]        EXP_ALL_ONES = 11'h7ff;
    localparam logic signed [11:0] NORM_BIAS    = 12'sd1022;
    localparam logic signed [11:0] SUBNORM_EXP  = -12'sd1021;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ZERO       = 2'd1,
        ST_NOT_FINITE = 2'd2
    } bre_status_t;

    // one classified value, octets in transmission order from index 0
    typedef struct packed {
        bre_status_t                     status;
        logic [3:0]                      count;
        logic [MAX_OCTETS-1:0][7:0]      octets;
    } bre_entry_t;

endpackage

// File: src/bre_front.sv
// ----------------------------------------------------------------------------
// bre_front
// Input register, classification, significand normalisation and octet build.
// ----------------------------------------------------------------------------
module bre_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [63:0]         s_tdata,
    output logic                push,
    output bre_pkg::bre_entry_t push_entry,
    input  logic                q_full
);
    import bre_pkg::*;

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic [63:0]        bits1_reg;

    logic               neg2_reg;
    bre_status_t        status2_reg;
    logic [63:0]        sig2_reg;
    logic signed [11:0] exp2_reg;

    logic               neg3_reg;
    bre_status_t        status3_reg;
    logic [63:0]        sig3_reg;
    logic signed [11:0] exp3_reg;

    bre_entry_t         entry4_reg;

    bre_status_t        status2_next;
    logic [63:0]        sig2_next;
    logic signed [11:0] exp2_next;
    logic [63:0]        sig3_next;
    logic signed [11:0] exp3_next;
    bre_entry_t         entry4_next;

    assign adv        = !v4_reg || !q_full;
    assign s_tready   = adv;
    assign push       = v4_reg && !q_full;
    assign push_entry = entry4_reg;

    // classify and coarse normalise
    always_comb begin
        logic [10:0] bexp;
        logic [51:0] frac;
        bexp = bits1_reg[62:52];
        frac = bits1_reg[51:0];
        if (bexp == EXP_ALL_ONES) begin
            status2_next = ST_NOT_FINITE;
        end else if (bexp == 11'd0 && frac == 52'd0) begin
            status2_next = ST_ZERO;
        end else begin
            status2_next = ST_OK;
        end
        sig2_next = {(bexp != 11'd0), frac, 11'd0};
        if (bexp == 11'd0) begin
            exp2_next = SUBNORM_EXP;
        end else begin
            exp2_next = $signed({1'b0, bexp}) - NORM_BIAS;
        end
        if (sig2_next[63:32] == 32'd0) begin
            sig2_next = {sig2_next[31:0], 32'd0};
            exp2_next = exp2_next - 12'sd32;
        end
        if (sig2_next[63:48] == 16'd0) begin
            sig2_next = {sig2_next[47:0], 16'd0};
            exp2_next = exp2_next - 12'sd16;
        end
        if (sig2_next[63:56] == 8'd0) begin
            sig2_next = {sig2_next[55:0], 8'd0};
            exp2_next = exp2_next - 12'sd8;
        end
    end

    // fine normalise
    always_comb begin
        sig3_next = sig2_reg;
        exp3_next = exp2_reg;
        if (sig3_next[63:60] == 4'd0) begin
            sig3_next = {sig3_next[59:0], 4'd0};
            exp3_next = exp3_next - 12'sd4;
        end
        if (sig3_next[63:62] == 2'd0) begin
            sig3_next = {sig3_next[61:0], 2'd0};
            exp3_next = exp3_next - 12'sd2;
        end
        if (sig3_next[63] == 1'b0) begin
            sig3_next = {sig3_next[62:0], 1'b0};
            exp3_next = exp3_next - 12'sd1;
        end
    end

    // trim trailing zero bytes, size the exponent, lay out the octets
    // (the lowest significand byte is always zero, so seven bytes at most)
    always_comb begin
        logic [3:0]         maxi;
        logic signed [11:0] expo;
        logic               wide;
        maxi = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (sig3_reg[63-8*i -: 8] != 8'd0) begin
                maxi = 4'(i + 1);
            end
        end
        expo = exp3_reg - $signed({5'd0, maxi, 3'd0});
        wide = !(expo[11:7] == 5'b00000 || expo[11:7] == 5'b11111);

        entry4_next        = '0;
        entry4_next.status = status3_reg;
        entry4_next.octets[0] = {1'b1, neg3_reg, 5'd0, wide};
        if (wide) begin
            entry4_next.octets[1] = {{4{expo[11]}}, expo[11:8]};
            entry4_next.octets[2] = expo[7:0];
            for (int k = 0; k < 7; k++) begin
                entry4_next.octets[3+k] = sig3_reg[63-8*k -: 8];
            end
            entry4_next.count = maxi + 4'd3;
        end else begin
            entry4_next.octets[1] = expo[7:0];
            for (int k = 0; k < 7; k++) begin
                entry4_next.octets[2+k] = sig3_reg[63-8*k -: 8];
            end
            entry4_next.count = maxi + 4'd2;
        end
        if (status3_reg != ST_OK) begin
            entry4_next.count = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            bits1_reg   <= s_tdata;
            neg2_reg    <= bits1_reg[63];
            status2_reg <= status2_next;
            sig2_reg    <= sig2_next;
            exp2_reg    <= exp2_next;
            neg3_reg    <= neg2_reg;
            status3_reg <= status2_reg;
            sig3_reg    <= sig3_next;
            exp3_reg    <= exp3_next;
            entry4_reg  <= entry4_next;
        end
    end

endmodule

// File: src/bre_queue.sv
// ----------------------------------------------------------------------------
// bre_queue
// Small FIFO of encoded values between the front and the octet serialiser.
// ----------------------------------------------------------------------------
module bre_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  bre_pkg::bre_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output bre_pkg::bre_entry_t head,
    output logic                empty
);
    import bre_pkg::*;

    bre_entry_t          store [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   fill_reg;

    assign full  = (fill_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = store[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: src/bre_back.sv
// ----------------------------------------------------------------------------
// bre_back
// Octet serialiser: walks the head entry one octet per transaction.
// ----------------------------------------------------------------------------
module bre_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  bre_pkg::bre_entry_t head,
    input  logic                q_empty,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,  // [7:0] octet, [11:8] octet_count
    output logic                m_tlast,
    output logic [1:0]          m_tuser   // [1:0] status
);
    import bre_pkg::*;

    logic [3:0]  idx_reg, idx_next;
    logic        ov_reg, ov_next;
    logic [7:0]  octet_reg;
    logic [3:0]  count_reg;
    logic        last_reg;
    bre_status_t status_reg;

    logic        load;
    logic        is_last;
    logic [7:0]  octet_sel;

    assign load    = !q_empty && (!ov_reg || m_tready);
    assign is_last = (head.status != ST_OK) || (idx_reg == head.count - 4'd1);
    assign pop     = load && is_last;

    always_comb begin
        octet_sel = (head.status == ST_OK) ? head.octets[idx_reg] : 8'd0;
        idx_next  = idx_reg;
        if (load) begin
            idx_next = is_last ? 4'd0 : idx_reg + 4'd1;
        end
        ov_next = ov_reg;
        if (load) begin
            ov_next = 1'b1;
        end else if (m_tready) begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 4'd0;
            ov_reg  <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            octet_reg  <= octet_sel;
            count_reg  <= head.count;
            last_reg   <= is_last;
            status_reg <= head.status;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'd0, count_reg, octet_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = status_reg;

endmodule

// File: src/ber_real_binary_encoder.sv
// ----------------------------------------------------------------------------
// ber_real_binary_encoder
// Binary64 pattern in, BER REAL base-2 content octets out.
// ----------------------------------------------------------------------------
// Each input transaction carries one binary64 pattern; the block returns one
// output transaction per content octet (3 to 10 for a finite nonzero value),
// with tlast on the final one. Zero and non-finite inputs return a single
// transaction with octet and count zero and the status in tuser. The front
// pipeline takes one value per cycle while it is not stalled; a four-entry
// queue then feeds the serialiser, which sends one octet per cycle while
// m_tready is high, one output transaction per content octet (one for zero
// or non-finite). Sustained throughput is set by that serialiser; the input
// stalls only once the queue is full.
// ----------------------------------------------------------------------------
module ber_real_binary_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] octet, [11:8] octet_count
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // [1:0] status
);
    import bre_pkg::*;

    logic       push, q_full, q_empty, pop;
    bre_entry_t push_entry, head;

    bre_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    bre_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty)
    );

    bre_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: tb/ber_real_binary_encoder_tb.sv
// ----------------------------------------------------------------------------
// ber_real_binary_encoder_tb
// Self-checking testbench for the BER REAL base-2 content octet encoder.
// ----------------------------------------------------------------------------
// Binary64 patterns go in as single transactions. The scoreboard works out
// every content octet expected from each accepted pattern and compares the
// octet stream field by field. Directed patterns cover signed zeros,
// infinities, NaNs, subnormals, the normal range ends and the one/two octet
// exponent boundary. They are followed by weighted random patterns. The
// sender runs in random bursts and the receiver stalls in shifting modes.
// ----------------------------------------------------------------------------
import bre_pkg::*;

class ber_octet_scoreboard;

    typedef struct {
        logic [7:0]  octet;
        logic [3:0]  count;
        logic        last;
        bre_status_t status;
    } octet_item_t;

    octet_item_t expected_octets[$];
    int errors;
    int values_seen;
    int zeros_seen;
    int nonfinite_seen;
    int subnormals_seen;
    int octets_checked;

    function new();
        errors          = 0;
        values_seen     = 0;
        zeros_seen      = 0;
        nonfinite_seen  = 0;
        subnormals_seen = 0;
        octets_checked  = 0;
    endfunction

    function void add_octet(logic [7:0] octet, logic [3:0] count, logic last,
                            bre_status_t status);
        octet_item_t item;
        item.octet  = octet;
        item.count  = count;
        item.last   = last;
        item.status = status;
        expected_octets.push_back(item);
    endfunction

    // predicts the content octets of one accepted binary64 pattern
    function void note_value(logic [63:0] bits);
        logic        neg;
        logic [10:0] bexp;
        logic [51:0] frac;
        logic [63:0] sig;
        int          expo;
        int          shift;
        int          sig_bytes;
        int          expmag;
        logic [7:0]  seq[$];
        values_seen++;
        neg  = bits[63];
        bexp = bits[62:52];
        frac = bits[51:0];
        if (bexp == EXP_ALL_ONES) begin
            nonfinite_seen++;
            add_octet(8'h00, 4'd0, 1'b1, ST_NOT_FINITE);
            return;
        end
        if (bexp == 11'd0 && frac == 52'd0) begin
            zeros_seen++;
            add_octet(8'h00, 4'd0, 1'b1, ST_ZERO);
            return;
        end
        if (bexp != 11'd0) begin
            sig  = {11'd0, 1'b1, frac};
            expo = int'(bexp) - 1022;
        end else begin
            subnormals_seen++;
            sig   = {12'd0, frac};
            shift = 0;
            while (!sig[52]) begin
                sig = sig << 1;
                shift++;
            end
            expo = -1021 - shift;
        end
        sig       = sig << 11;
        sig_bytes = 0;
        for (int i = 0; i < 8; i++) begin
            if (sig[63 - 8*i -: 8] != 8'h00)
                sig_bytes = i + 1;
        end
        expo   = expo - 8 * sig_bytes;
        expmag = (expo >= 0) ? expo : -(expo + 1);
        seq.push_back({1'b1, neg, 5'b00000, expmag >= 128});
        if (expmag >= 128)
            seq.push_back(expo[15:8]);
        seq.push_back(expo[7:0]);
        for (int i = 0; i < sig_bytes; i++)
            seq.push_back(sig[63 - 8*i -: 8]);
        for (int k = 0; k < seq.size(); k++)
            add_octet(seq[k], 4'(seq.size()), k == seq.size() - 1, ST_OK);
    endfunction

    function void check_octet(logic [7:0] octet, logic [3:0] count, logic last,
                              logic [1:0] status);
        octet_item_t want;
        octets_checked++;
        if (expected_octets.size() == 0) begin
            $error("unexpected octet transaction: octet %h count %0d last %b status %0d",
                   octet, count, last, status);
            errors++;
            return;
        end
        want = expected_octets.pop_front();
        if (octet !== want.octet) begin
            $error("octet: expected %h, got %h", want.octet, octet);
            errors++;
        end
        if (count !== want.count) begin
            $error("octet_count: expected %0d, got %0d", want.count, count);
            errors++;
        end
        if (last !== want.last) begin
            $error("last: expected %b, got %b", want.last, last);
            errors++;
        end
        if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
        end
    endfunction

    function int outstanding();
        return expected_octets.size();
    endfunction

endclass

module ber_real_binary_encoder_tb;

    localparam int RANDOM_VALUES = 96;
    localparam int TAIL_CYCLES   = 20;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = 64'd0;   // [63:0] value_bits
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [7:0] octet, [11:8] octet_count
    logic        m_tlast;
    logic [1:0]  m_tuser;            // [1:0] status

    ber_octet_scoreboard sb;

    ber_real_binary_encoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(12 * 200000);
        $display("Some tests failed");
        $finish;
    end

    // called at a rising edge; returns at the edge where the transaction completes
    task automatic send_value(input logic [63:0] bits);
        s_tvalid <= 1'b1;
        s_tdata  <= bits;
        do @(posedge aclk); while (!s_tready);
        sb.note_value(bits);
    endtask

    task automatic idle_sender(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] raw;
        logic [51:0] frac;
        logic [10:0] bexp;
        int          pick;
        int          cut;
        raw  = {$urandom, $urandom};
        frac = raw[51:0];
        pick = $urandom_range(0, 99);
        cut  = $urandom_range(0, 6);
        if (cut > 0)
            frac = frac & ~((52'd1 << (8 * cut)) - 52'd1);
        if (pick < 5)
            return {raw[63], 63'd0};
        if (pick < 10)
            return {raw[63], 11'h7ff, raw[51:0]};
        if (pick < 25) begin
            if (frac == 52'd0)
                frac = 52'd1 << $urandom_range(0, 51);
            return {raw[63], 11'd0, frac};
        end
        if (pick < 40)
            return raw;
        case ($urandom_range(0, 5))
            0:       bexp = 11'd901 + 11'($urandom_range(0, 1));
            1:       bexp = 11'd1157 + 11'($urandom_range(0, 1));
            2:       bexp = 11'($urandom_range(0, 1) ? 2046 : 1);
            default: bexp = 11'($urandom_range(1, 2046));
        endcase
        return {raw[63], bexp, frac};
    endfunction

    // receiver: checks each accepted octet; the ready pattern switches between random modes
    initial begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_octet(m_tdata[7:0], m_tdata[11:8], m_tlast, m_tuser);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(16, 80);
            end
            left--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 5) == 0);
                default: m_tready <= (left % 8) < 5;
            endcase
        end
    end

    initial begin
        logic [63:0] directed[$];
        int          burst;
        sb = new();
        directed = '{
            64'h0000_0000_0000_0000,  // +0
            64'h8000_0000_0000_0000,  // -0
            64'h7ff0_0000_0000_0000,  // +inf
            64'hfff0_0000_0000_0000,  // -inf
            64'h7ff8_0000_0000_0000,  // quiet NaN
            64'h7ff0_0000_0000_0001,  // signalling NaN
            64'hffff_ffff_ffff_ffff,  // NaN, all ones
            64'h0000_0000_0000_0001,  // smallest subnormal
            64'h800f_ffff_ffff_ffff,  // largest subnormal, negative
            64'h0008_0000_0000_0000,  // subnormal, top fraction bit
            64'h0010_0000_0000_0000,  // smallest normal
            64'h7fef_ffff_ffff_ffff,  // largest normal
            64'hffef_ffff_ffff_ffff,  // most negative normal
            64'h3ff0_0000_0000_0000,  // 1.0
            64'hbff0_0000_0000_0000,  // -1.0
            64'h3fe0_0000_0000_0000,  // 0.5
            64'h4850_0000_0000_0000,  // exponent +127, one octet
            64'h4860_0000_0000_0000,  // exponent +128, two octets
            64'h3860_0000_0000_0000,  // exponent -128, one octet
            64'h3850_0000_0000_0000,  // exponent -129, two octets
            64'h3ff0_0000_0000_0100,  // six significand bytes
            64'h4000_0000_0000_0001,  // lowest fraction bit
            64'h5555_5555_5555_5555,
            64'h2aaa_aaaa_aaaa_aaaa
        };
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            send_value(directed[i]);
            if ($urandom_range(0, 3) == 0)
                idle_sender($urandom_range(1, 6));
        end
        drain_results();

        burst = 0;
        for (int n = 0; n < RANDOM_VALUES; n++) begin
            if (n == RANDOM_VALUES / 2)
                drain_results();
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 2) != 0)
                    idle_sender($urandom_range(1, 15));
            end
            burst--;
            send_value(random_value());
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d values: %0d zero, %0d non-finite, %0d subnormal.",
                 sb.values_seen, sb.zeros_seen, sb.nonfinite_seen, sb.subnormals_seen);
        $display("Checked %0d octet transactions under bursty input and varied stalls.",
                 sb.octets_checked);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
